>>> rtl/core/dtm_pkg.sv
// ----------------------------------------------------------------------------
// Dither threshold generator package
// Shared types and register map for the threshold generator pipeline.
// ----------------------------------------------------------------------------
package dtm_pkg;

    // Field widths.
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned SLOPE_W  = 5;
    localparam int unsigned OFFSET_W = 8;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned RANK_W   = 4;
    localparam int unsigned BOUND_W  = 2;

    // Configuration port.
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_SLOPE  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_OFFSET = 3'd4;

    // Level arithmetic.
    localparam logic [8:0] LEVEL_BASE = 9'd146;
    localparam logic [8:0] LEVEL_MAX  = 9'd255;

    // Decode stage to level stage.
    typedef struct packed {
        logic               valid;
        logic               oor;
        logic [BOUND_W-1:0] bound;
        logic [RANK_W-1:0]  rank;
    } t_dec;

    // Level stage to interpolation stage.
    typedef struct packed {
        logic               valid;
        logic               oor;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic [RANK_W-1:0]  rank;
    } t_lvl;

endpackage

>>> rtl/core/dtm_decode.sv
// ----------------------------------------------------------------------------
// Entry decode stage
// Splits a table entry into shade boundary and pixel rank, one per cycle unless the next stage stalls.
// ----------------------------------------------------------------------------
module dtm_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [dtm_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic                         i_ready,
    output logic                         o_ready,
    output dtm_pkg::t_dec                o_dec
);

    // Pixel rank of each matrix cell (inverse of the rank-to-cell layout).
    localparam logic [15:0][dtm_pkg::RANK_W-1:0] RANK_OF_CELL = {
        4'd5, 4'd9, 4'd6, 4'd10, 4'd13, 4'd1, 4'd14, 4'd2,
        4'd7, 4'd11, 4'd4, 4'd8, 4'd15, 4'd3, 4'd12, 4'd0
    };

    logic                         r_valid;
    logic                         r_oor;
    logic [dtm_pkg::BOUND_W-1:0]  r_bound;
    logic [dtm_pkg::RANK_W-1:0]   r_rank;
    logic                         n_oor;
    logic [dtm_pkg::BOUND_W-1:0]  n_bound;
    logic [dtm_pkg::RANK_W-1:0]   n_rank;
    logic [12:0]                  w_scaled;
    logic [dtm_pkg::RANK_W-1:0]   w_cell;
    logic [dtm_pkg::INDEX_W-1:0]  w_three_cell;
    logic                         w_en;

    // The stage loads when it is empty or its content moves on.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Division by three as a multiply by 43/128, exact for indexes below 48.
    always_comb begin
        w_scaled     = 13'(i_entry_index) * 13'd43;
        w_cell       = w_scaled[10:7];
        w_three_cell = dtm_pkg::INDEX_W'({w_cell, 1'b0}) + dtm_pkg::INDEX_W'(w_cell);
        n_oor        = (i_entry_index >= 6'd48);
        n_bound      = dtm_pkg::BOUND_W'(i_entry_index - w_three_cell);
        n_rank       = RANK_OF_CELL[w_cell];
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_oor   <= n_oor;
            r_bound <= n_bound;
            r_rank  <= n_rank;
        end
    end

    assign o_dec = '{valid: r_valid, oor: r_oor, bound: r_bound, rank: r_rank};

endmodule

>>> rtl/core/dtm_level.sv
// ----------------------------------------------------------------------------
// Contrast level stage
// Forms the two contrast levels that bracket the entry's shade boundary.
// ----------------------------------------------------------------------------
module dtm_level (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dtm_pkg::SLOPE_W-1:0]   i_slope,
    input  logic [dtm_pkg::OFFSET_W-1:0]  i_offset,
    input  dtm_pkg::t_dec                 i_dec,
    input  logic                          i_ready,
    output logic                          o_ready,
    output dtm_pkg::t_lvl                 o_lvl
);

    logic                          r_valid;
    logic                          r_oor;
    logic [dtm_pkg::LEVEL_W-1:0]   r_lo;
    logic [dtm_pkg::LEVEL_W-1:0]   r_hi;
    logic [dtm_pkg::RANK_W-1:0]    r_rank;
    logic [8:0]                    w_base;
    logic [8:0]                    w_lo_sum;
    logic [8:0]                    w_hi_sum;
    logic [dtm_pkg::LEVEL_W-1:0]   n_lo;
    logic [dtm_pkg::LEVEL_W-1:0]   n_hi;
    logic                          w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Level L is base + L*slope; the sum stays below 512 and saturates at 255.
    always_comb begin
        w_base   = 9'(i_offset) + dtm_pkg::LEVEL_BASE - 9'(i_slope >> 1);
        w_lo_sum = w_base + 9'(i_dec.bound) * 9'(i_slope);
        w_hi_sum = w_lo_sum + 9'(i_slope);
        n_lo     = (w_lo_sum > dtm_pkg::LEVEL_MAX) ? 8'hFF : w_lo_sum[7:0];
        n_hi     = (w_hi_sum > dtm_pkg::LEVEL_MAX) ? 8'hFF : w_hi_sum[7:0];
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_dec.valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_en && i_dec.valid) begin
            r_oor  <= i_dec.oor;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_rank <= i_dec.rank;
        end
    end

    assign o_lvl = '{valid: r_valid, oor: r_oor, lo: r_lo, hi: r_hi, rank: r_rank};

endmodule

>>> rtl/core/dtm_interp.sv
// ----------------------------------------------------------------------------
// Interpolation stage
// Blends the two levels by pixel rank and holds the result for the receiver.
// ----------------------------------------------------------------------------
module dtm_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtm_pkg::t_lvl                 i_lvl,
    input  logic                          i_ready,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [dtm_pkg::LEVEL_W-1:0]   o_threshold
);

    logic                          r_valid;
    logic [dtm_pkg::LEVEL_W-1:0]   r_threshold;
    logic [dtm_pkg::LEVEL_W-1:0]   w_diff;
    logic [11:0]                   w_prod;
    logic [12:0]                   w_acc;
    logic [dtm_pkg::LEVEL_W-1:0]   n_threshold;
    logic                          w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Levels never decrease, so the difference is never negative.
    always_comb begin
        w_diff      = i_lvl.hi - i_lvl.lo;
        w_prod      = 12'(i_lvl.rank) * 12'(w_diff);
        w_acc       = 13'({i_lvl.lo, 4'b0000}) + 13'(w_prod);
        n_threshold = i_lvl.oor ? '0 : w_acc[11:4];
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_lvl.valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_en && i_lvl.valid) begin
            r_threshold <= n_threshold;
        end
    end

    assign o_valid     = r_valid;
    assign o_threshold = r_threshold;

endmodule

>>> rtl/core/dither_threshold_matrix_gen_top.sv
// ----------------------------------------------------------------------------
// Dither threshold generator
// Produces one threshold byte of a 48-entry 4x4 ordered dither table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry an entry index; a transfer happens
//   at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry the threshold byte; a transfer
//   happens at a clock edge with o_valid high and i_stall low.
//   Indexes 48 to 63 return a threshold of zero.
//   The APB port sets contrast_slope (address 0) and contrast_offset
//   (address 4); write them only while no entry is in flight.
//   An input transfer passes through the decode, contrast level and
//   interpolation register stages in that order before o_valid rises; one
//   entry is taken every cycle unless the receiver stalls. Each of the three
//   register stages has its own valid bit.
//   When the receiver stalls, each stage holds its entry, and o_stall rises
//   only once the first stage is full; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and clears both registers to 0.
// ----------------------------------------------------------------------------
module dither_threshold_matrix_gen_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [dtm_pkg::INDEX_W-1:0]    i_entry_index,
    // Output channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dtm_pkg::LEVEL_W-1:0]    o_threshold,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dtm_pkg::ADDR_W-1:0]     paddr,
    input  logic [dtm_pkg::DATA_W-1:0]     pwdata,
    output logic [dtm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic [dtm_pkg::SLOPE_W-1:0]   r_slope;
    logic [dtm_pkg::OFFSET_W-1:0]  r_offset;
    logic                          w_wr;
    dtm_pkg::t_dec                 w_dec;
    dtm_pkg::t_lvl                 w_lvl;
    logic                          w_rdy1;
    logic                          w_rdy2;
    logic                          w_rdy3;

    // Configuration registers.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= '0;
            r_offset <= '0;
        end else if (w_wr) begin
            if (paddr == dtm_pkg::ADDR_SLOPE) begin
                r_slope <= pwdata[dtm_pkg::SLOPE_W-1:0];
            end
            if (paddr == dtm_pkg::ADDR_OFFSET) begin
                r_offset <= pwdata[dtm_pkg::OFFSET_W-1:0];
            end
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr)
            dtm_pkg::ADDR_SLOPE:  prdata = dtm_pkg::DATA_W'(r_slope);
            dtm_pkg::ADDR_OFFSET: prdata = dtm_pkg::DATA_W'(r_offset);
            default:              prdata = '0;
        endcase
    end

    // Pipeline stages.
    dtm_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_entry_index (i_entry_index),
        .i_ready       (w_rdy2),
        .o_ready       (w_rdy1),
        .o_dec         (w_dec)
    );

    dtm_level u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_slope  (r_slope),
        .i_offset (r_offset),
        .i_dec    (w_dec),
        .i_ready  (w_rdy3),
        .o_ready  (w_rdy2),
        .o_lvl    (w_lvl)
    );

    dtm_interp u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lvl       (w_lvl),
        .i_ready     (!i_stall),
        .o_ready     (w_rdy3),
        .o_valid     (o_valid),
        .o_threshold (o_threshold)
    );

    assign o_stall = !w_rdy1;

`ifndef SYNTHESIS
    // A stall toward the sender only happens with the first stage occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_dec.valid)
        else $error("input stalled while decode stage is empty");

    // An accepted index always lands in the decode stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_dec.valid)
        else $error("accepted entry lost at decode stage");

    // A level entry that moves on always reaches the output register.
    a_lvl_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lvl.valid && w_rdy3) |=> o_valid)
        else $error("level stage entry lost");

    // Contrast levels are monotonic, so the upper level never falls below.
    a_level_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lvl.valid |-> (w_lvl.hi >= w_lvl.lo))
        else $error("upper contrast level below lower level");
`endif

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Dither threshold generator testbench
// Streams entry indexes through the generator under several contrast settings
// and compares every threshold byte against an in-bench prediction, with
// random idling on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PIPE_LATENCY = 3;
    localparam int unsigned IDLE_PCT     = 32;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned TABLE_SIZE   = 48;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS  = 190;

    // ------------------------------------------------------------------------
    // Threshold scoreboard: keeps its own copy of the contrast registers,
    // predicts each threshold at input transfer and checks results in order.
    // ------------------------------------------------------------------------
    class threshold_scoreboard;
        logic [dtm_pkg::SLOPE_W-1:0]  slope;
        logic [dtm_pkg::OFFSET_W-1:0] offset;
        logic [dtm_pkg::LEVEL_W-1:0]  pending_thresholds[$];
        int unsigned                  mismatches;
        int unsigned                  checked;

        function new();
            slope      = '0;
            offset     = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_register(logic [dtm_pkg::ADDR_W-1:0] addr,
                                     logic [dtm_pkg::DATA_W-1:0] data);
            if (addr == dtm_pkg::ADDR_SLOPE) begin
                slope = data[dtm_pkg::SLOPE_W-1:0];
            end else if (addr == dtm_pkg::ADDR_OFFSET) begin
                offset = data[dtm_pkg::OFFSET_W-1:0];
            end
        endfunction

        // Contrast level, saturated to the largest byte value.
        function int unsigned contrast_level(int unsigned lvl);
            int unsigned v;
            v = int'(offset) + int'(dtm_pkg::LEVEL_BASE) - (int'(slope) >> 1)
                + lvl * int'(slope);
            return (v > int'(dtm_pkg::LEVEL_MAX)) ? int'(dtm_pkg::LEVEL_MAX) : v;
        endfunction

        // Pixel rank of each matrix cell, the inverse of the rank-to-cell layout.
        function int unsigned rank_of_cell(int unsigned cell_idx);
            case (cell_idx)
                0:  return 0;
                1:  return 12;
                2:  return 3;
                3:  return 15;
                4:  return 8;
                5:  return 4;
                6:  return 11;
                7:  return 7;
                8:  return 2;
                9:  return 14;
                10: return 1;
                11: return 13;
                12: return 10;
                13: return 6;
                14: return 9;
                default: return 5;
            endcase
        endfunction

        // Interpolate between the two contrast levels around the shade boundary.
        function logic [dtm_pkg::LEVEL_W-1:0] predict_threshold(
            logic [dtm_pkg::INDEX_W-1:0] idx);
            int unsigned bound;
            int unsigned rank;
            int unsigned lo;
            int unsigned hi;
            int unsigned acc;
            if (idx >= TABLE_SIZE) begin
                return '0;
            end
            bound = int'(idx) % 3;
            rank  = rank_of_cell(int'(idx) / 3);
            lo    = contrast_level(bound);
            hi    = contrast_level(bound + 1);
            acc   = lo * 16 + rank * (hi - lo);
            return dtm_pkg::LEVEL_W'(acc >> 4);
        endfunction

        function void note_entry(logic [dtm_pkg::INDEX_W-1:0] idx);
            pending_thresholds.push_back(predict_threshold(idx));
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("ERROR: %s", what);
            end
        endfunction

        function void check_threshold(logic [dtm_pkg::LEVEL_W-1:0] got);
            logic [dtm_pkg::LEVEL_W-1:0] want;
            if (pending_thresholds.size() == 0) begin
                report_mismatch($sformatf("threshold %0d arrived with none pending", got));
            end else begin
                want = pending_thresholds.pop_front();
                checked++;
                if (got !== want) begin
                    report_mismatch($sformatf("threshold #%0d: expected %0d, got %0d",
                                              checked, want, got));
                end
            end
        endfunction

        function int unsigned pending();
            return pending_thresholds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_valid       = 1'b0;
    logic                         o_stall;
    logic [dtm_pkg::INDEX_W-1:0]  i_entry_index = '0;
    logic                         o_valid;
    logic                         i_stall       = 1'b0;
    logic [dtm_pkg::LEVEL_W-1:0]  o_threshold;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [dtm_pkg::ADDR_W-1:0]   paddr         = '0;
    logic [dtm_pkg::DATA_W-1:0]   pwdata        = '0;
    logic [dtm_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    threshold_scoreboard sb = new();
    bit                  steady_flow   = 1'b0;
    int unsigned         cycles        = 0;
    int unsigned         entries_sent  = 0;
    int unsigned         settings_used = 0;

    dither_threshold_matrix_gen_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_threshold   (o_threshold),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("dither_threshold_matrix_gen_top: mismatch");
            $finish;
        end
    end

    // Receiver stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        i_stall = steady_flow ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    // Check every threshold transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_threshold(o_threshold);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one entry index, with random idle cycles ahead of it, and wait
    // for its transfer. Valid stays high afterwards for a back-to-back entry.
    task automatic send_entry(logic [dtm_pkg::INDEX_W-1:0] idx);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_entry_index = idx;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.note_entry(idx);
        entries_sent++;
    endtask

    // Drop valid and hold off until every pending threshold has arrived.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(logic [dtm_pkg::ADDR_W-1:0] addr,
                                  logic [dtm_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.write_register(addr, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_contrast(logic [dtm_pkg::DATA_W-1:0] slope,
                                logic [dtm_pkg::DATA_W-1:0] offset);
        write_register(dtm_pkg::ADDR_SLOPE, slope);
        write_register(dtm_pkg::ADDR_OFFSET, offset);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [dtm_pkg::INDEX_W-1:0] boundary_idx[16];
        logic [dtm_pkg::INDEX_W-1:0] saturate_idx[5];
        logic [dtm_pkg::INDEX_W-1:0] reset_idx[4];
        logic [dtm_pkg::DATA_W-1:0]  slope_val;
        logic [dtm_pkg::DATA_W-1:0]  offset_val;

        boundary_idx = '{0, 1, 2, 3, 5, 15, 16, 31, 32, 44, 45, 46, 47, 48, 55, 63};
        saturate_idx = '{0, 1, 2, 45, 47};
        reset_idx    = '{0, 46, 47, 63};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: registers at their reset values, then a wide slope, then
        // an offset that drives the upper levels into saturation.
        foreach (reset_idx[k]) send_entry(reset_idx[k]);
        drain_pipeline();
        set_contrast(31, 100);
        foreach (boundary_idx[k]) send_entry(boundary_idx[k]);
        drain_pipeline();
        set_contrast(31, 255);
        foreach (saturate_idx[k]) send_entry(saturate_idx[k]);
        drain_pipeline();

        // Random phases: extreme settings first, then random register words.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin slope_val = 0;  offset_val = 255; end
                1: begin slope_val = 31; offset_val = 0;   end
                2: begin slope_val = 0;  offset_val = 0;   end
                3: begin slope_val = 31; offset_val = 255; end
                default: begin
                    slope_val  = $urandom;
                    offset_val = $urandom;
                end
            endcase
            set_contrast(slope_val, offset_val);
            steady_flow = (ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 88) begin
                    send_entry(dtm_pkg::INDEX_W'($urandom_range(TABLE_SIZE - 1)));
                end else begin
                    send_entry(dtm_pkg::INDEX_W'($urandom_range(63, TABLE_SIZE)));
                end
            end
            drain_pipeline();
            steady_flow = 1'b0;
        end

        // Final settle; the drain above already waited out the pipeline.
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("Run covered %0d entry indexes over %0d contrast settings.",
                 entries_sent, settings_used + 1);
        $display("%0d thresholds checked, %0d mismatches, %0d still pending.",
                 sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("dither_threshold_matrix_gen_top: match");
        end else begin
            $display("dither_threshold_matrix_gen_top: mismatch");
        end
        $finish;
    end

endmodule
